[hw/rtl/acpc_pkg.sv]
// ----------------------------------------------------------------------------
// acpc_pkg
// Shared types, opcodes, register indexes and constants for the pill-counting
// 12-hour alarm clock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acpc_pkg;

  // Event opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_TAKE = 2'd2;
  localparam logic [1:0] OP_SET  = 2'd3;

  // Config register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALM_HOUR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALM_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALM_PM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALM_ARMED = 3'd4;

  localparam int CFG_DATA_W = 20;
  localparam int PILL_W     = 20;

  localparam int ACPC_TICKS_PER_SECOND = 100;

  // Clock limits
  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [3:0] HOUR_TOP  = 4'd12;
  localparam logic [3:0] HOUR_FLIP = 4'd11;

  // Pill count wraps from this value to one
  localparam logic [PILL_W-1:0] PILL_MAX = 20'd999999;
  localparam logic [PILL_W-1:0] THRESHOLD_RESET = 20'd5;

  // Buzzer pulse windows, in subticks (lower bound in, upper bound out)
  localparam int BEEP_ON_A  = 35;
  localparam int BEEP_OFF_A = 40;
  localparam int BEEP_ON_B  = 45;
  localparam int BEEP_OFF_B = 50;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] set_hour;
    logic [5:0] set_minute;
    logic       set_pm;
  } acpc_in_t;

  typedef struct packed {
    logic [3:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic              pm;
    logic [PILL_W-1:0] pill_count;
    logic              beep_active;
    logic              buzzer;
    logic              alarm_pending;
    logic              no_pills;
  } acpc_out_t;

  // Clock state after an item, plus the buzzer window flag
  typedef struct packed {
    logic [3:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       pm;
    logic       buzz_window;
  } acpc_time_t;

  // Pill counter state after an item
  typedef struct packed {
    logic [PILL_W-1:0] count;
    logic              empty;
  } acpc_pill_t;

endpackage

`default_nettype wire

[hw/rtl/alarm_clock_pill_counter.sv]
// ----------------------------------------------------------------------------
// alarm_clock_pill_counter
// Pill-counting 12-hour alarm clock. Every accepted input word is one event
// (10 ms tick, add pill, take pill, set time) and yields exactly one result
// word holding the clock, pill count and warning state after that event.
// Throughput is one word per cycle unless out_ready stalls it: the event is
// applied to the clock and pill registers in the cycle it is accepted, and
// its result lands in the output register on the same edge. The output
// register is the only stage, so in_ready is high whenever that register is
// empty or being drained this cycle. Config registers (threshold, alarm
// hour/minute/PM, armed) are written through cfg_we/cfg_idx/cfg_wdata, take
// effect on the next event, and should only change while the block is idle;
// indexes past the last register are ignored. The alarm matches at
// hh:mm:00 while armed and latches pending until a take; the buzzer pulses
// in subticks 35-39 and 45-49 of each second while the warning is active.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alarm_clock_pill_counter
  import acpc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = ACPC_TICKS_PER_SECOND
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // event input
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire acpc_in_t              in_data,
  // result output
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      acpc_out_t             out_data,
  // config writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Config registers
  logic [PILL_W-1:0] thresh_r;
  logic [3:0]        alm_hour_r;
  logic [5:0]        alm_min_r;
  logic              alm_pm_r;
  logic              alm_armed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESHOLD_RESET;
      alm_hour_r  <= HOUR_TOP;
      alm_min_r   <= '0;
      alm_pm_r    <= 1'b0;
      alm_armed_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_THRESHOLD: thresh_r    <= cfg_wdata[PILL_W-1:0];
        REG_ALM_HOUR:  alm_hour_r  <= cfg_wdata[3:0];
        REG_ALM_MIN:   alm_min_r   <= cfg_wdata[5:0];
        REG_ALM_PM:    alm_pm_r    <= cfg_wdata[0];
        REG_ALM_ARMED: alm_armed_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register frees up as it drains
  logic out_valid_r;
  logic accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Event processing units; state advances on accept
  acpc_time_t time_nxt;
  acpc_pill_t pill_nxt;

  acpc_time #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (accept),
    .item     (in_data),
    .time_nxt (time_nxt)
  );

  acpc_pill u_pill (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (accept),
    .opcode   (in_data.opcode),
    .pill_nxt (pill_nxt)
  );

  // Alarm match uses the post-event time; a match wins over a take's ack.
  // An out-of-range alarm hour/minute can never equal the clock, so it
  // simply never fires.
  logic pending_r, pending_nxt;
  logic match;
  logic beep;

  assign match = alm_armed_r && (time_nxt.second == '0) &&
                 (time_nxt.minute == alm_min_r) &&
                 (time_nxt.hour == alm_hour_r) &&
                 (time_nxt.pm == alm_pm_r);

  always_comb begin
    if (match) begin
      pending_nxt = 1'b1;
    end else if (in_data.opcode == OP_TAKE) begin
      pending_nxt = 1'b0;
    end else begin
      pending_nxt = pending_r;
    end
  end

  assign beep = (pill_nxt.count < thresh_r) || match || pending_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else if (accept) begin
      pending_r <= pending_nxt;
    end
  end

  // Output register
  acpc_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.hour          <= time_nxt.hour;
      out_data_r.minute        <= time_nxt.minute;
      out_data_r.second        <= time_nxt.second;
      out_data_r.pm            <= time_nxt.pm;
      out_data_r.pill_count    <= pill_nxt.count;
      out_data_r.beep_active   <= beep;
      out_data_r.buzzer        <= beep && time_nxt.buzz_window;
      out_data_r.alarm_pending <= pending_nxt;
      out_data_r.no_pills      <= pill_nxt.empty;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hw/rtl/acpc_time.sv]
// ----------------------------------------------------------------------------
// acpc_time
// 12-hour time keeper: subtick, seconds, minutes, hours 1..12 and PM flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acpc_time
  import acpc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = ACPC_TICKS_PER_SECOND
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire acpc_in_t   item,
  output acpc_time_t      time_nxt
);

  localparam int SUB_W = $clog2(TICKS_PER_SECOND);
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic [5:0]       sec_r, sec_nxt;
  logic [5:0]       min_r, min_nxt;
  logic [3:0]       hour_r, hour_nxt;
  logic             pm_r, pm_nxt;

  always_comb begin
    sub_nxt  = sub_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    pm_nxt   = pm_r;
    unique case (item.opcode)
      OP_TICK: begin
        if (sub_r >= SUB_LAST) begin
          sub_nxt = '0;
          if (sec_r >= SEC_LAST) begin
            sec_nxt = '0;
            if (min_r >= MIN_LAST) begin
              min_nxt = '0;
              if (hour_r >= HOUR_TOP) begin
                hour_nxt = 4'd1;
              end else begin
                hour_nxt = hour_r + 4'd1;
                if (hour_r == HOUR_FLIP) begin
                  pm_nxt = ~pm_r;
                end
              end
            end else begin
              min_nxt = min_r + 6'd1;
            end
          end else begin
            sec_nxt = sec_r + 6'd1;
          end
        end else begin
          sub_nxt = sub_r + SUB_W'(1);
        end
      end
      OP_SET: begin
        // out-of-range hour loads 12, out-of-range minute loads 59
        hour_nxt = (item.set_hour == 4'd0 || item.set_hour > HOUR_TOP) ?
                   HOUR_TOP : item.set_hour;
        min_nxt  = (item.set_minute > MIN_LAST) ? MIN_LAST : item.set_minute;
        pm_nxt   = item.set_pm;
        sec_nxt  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r  <= '0;
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= HOUR_TOP;
      pm_r   <= 1'b0;
    end else if (step_en) begin
      sub_r  <= sub_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      pm_r   <= pm_nxt;
    end
  end

  always_comb begin
    time_nxt.hour        = hour_nxt;
    time_nxt.minute      = min_nxt;
    time_nxt.second      = sec_nxt;
    time_nxt.pm          = pm_nxt;
    time_nxt.buzz_window =
      (sub_nxt >= SUB_W'(BEEP_ON_A) && sub_nxt < SUB_W'(BEEP_OFF_A)) ||
      (sub_nxt >= SUB_W'(BEEP_ON_B) && sub_nxt < SUB_W'(BEEP_OFF_B));
  end

endmodule

`default_nettype wire

[hw/rtl/acpc_pill.sv]
// ----------------------------------------------------------------------------
// acpc_pill
// Six-digit pill counter: add wraps 999999 to 1, take holds at zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acpc_pill
  import acpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [1:0] opcode,
  output acpc_pill_t      pill_nxt
);

  logic [PILL_W-1:0] count_r, count_nxt;
  logic              empty;

  always_comb begin
    count_nxt = count_r;
    empty     = 1'b0;
    unique case (opcode)
      OP_ADD: begin
        count_nxt = (count_r >= PILL_MAX) ? PILL_W'(1) : count_r + PILL_W'(1);
      end
      OP_TAKE: begin
        if (count_r == '0) begin
          empty = 1'b1;
        end else begin
          count_nxt = count_r - PILL_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step_en) begin
      count_r <= count_nxt;
    end
  end

  assign pill_nxt.count = count_nxt;
  assign pill_nxt.empty = empty;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pill-counting 12-hour alarm clock. Event words
// go in over a valid/ready channel, and a local model of the clock, the pill
// counter and the alarm predicts one result word per event. The checker
// compares each result, field by field, with the oldest prediction. Tests run
// in turn: reset values and basic ops, alarm matching with register corner
// values, second rollovers through the buzzer windows, random phases under
// changing settings, and a final back-to-back run with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import acpc_pkg::*;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  acpc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  acpc_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  alarm_clock_pill_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Local copy of the config registers, at reset values
  // --------------------------------------------------------------------------
  logic [19:0] thr_reg   = THRESHOLD_RESET;
  logic [3:0]  alm_hour  = HOUR_TOP;
  logic [5:0]  alm_min   = '0;
  logic        alm_pm    = 1'b0;
  logic        alm_armed = 1'b0;

  // Clock / pill / alarm state as the block should hold it
  int          sub_cnt  = 0;
  logic [5:0]  sec_cnt  = '0;
  logic [5:0]  min_cnt  = '0;
  logic [3:0]  hr_cnt   = HOUR_TOP;
  logic        pm_flag  = 1'b0;
  logic [19:0] pill_cnt = '0;
  logic        pend     = 1'b0;

  // Results predicted but not yet seen, oldest first
  acpc_out_t   awaited_words[$];

  // Idle knobs, percent chance per word / per cycle of starting a burst
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;

  // Stats and score
  int events_taken   = 0;
  int words_checked  = 0;
  int mismatch_count = 0;
  int alarm_hits     = 0;
  int empty_takes    = 0;
  int buzz_words     = 0;

  // Hard stop far past the slowest legal run
  initial begin
    #10_000_000;
    $display("Timeout: run did not finish, %0d words still awaited", awaited_words.size());
    $display("** alarm_clock_pill_counter: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: apply one event to the local state, return the result word
  // --------------------------------------------------------------------------
  function automatic acpc_out_t clock_after_event(acpc_in_t w);
    acpc_out_t  r;
    logic [3:0] hr;
    logic [5:0] mn;
    logic       hit;
    logic       warn;
    logic       empty;
    logic       in_win;
    empty = 1'b0;
    case (w.opcode)
      OP_TICK: begin
        if (sub_cnt == ACPC_TICKS_PER_SECOND - 1) begin
          sub_cnt = 0;
          if (sec_cnt == SEC_LAST) begin
            sec_cnt = '0;
            if (min_cnt == MIN_LAST) begin
              min_cnt = '0;
              // 12 -> 1 keeps the half; 11 -> 12 flips it
              if (hr_cnt >= HOUR_TOP) begin
                hr_cnt = 4'd1;
              end else begin
                hr_cnt = hr_cnt + 4'd1;
                if (hr_cnt == HOUR_TOP) pm_flag = ~pm_flag;
              end
            end else begin
              min_cnt = min_cnt + 6'd1;
            end
          end else begin
            sec_cnt = sec_cnt + 6'd1;
          end
        end else begin
          sub_cnt++;
        end
      end
      OP_ADD: begin
        if (pill_cnt >= PILL_MAX) begin
          pill_cnt = 20'd1;
        end else begin
          pill_cnt = pill_cnt + 20'd1;
        end
      end
      OP_TAKE: begin
        pend = 1'b0;
        if (pill_cnt == '0) begin
          empty = 1'b1;
          empty_takes++;
        end else begin
          pill_cnt = pill_cnt - 20'd1;
        end
      end
      OP_SET: begin
        // out-of-range hours load 12, minutes clamp to 59; subtick kept
        hr = w.set_hour;
        if (hr == 4'd0 || hr > HOUR_TOP) hr = HOUR_TOP;
        mn = (w.set_minute > MIN_LAST) ? MIN_LAST : w.set_minute;
        hr_cnt  = hr;
        min_cnt = mn;
        pm_flag = w.set_pm;
        sec_cnt = '0;
      end
      default: ;
    endcase

    hit = alm_armed && sec_cnt == '0 && min_cnt == alm_min &&
          hr_cnt == alm_hour && pm_flag == alm_pm;
    if (hit) begin
      pend = 1'b1;
      alarm_hits++;
    end
    warn   = (pill_cnt < thr_reg) || hit || pend;
    in_win = (sub_cnt >= BEEP_ON_A && sub_cnt < BEEP_OFF_A) ||
             (sub_cnt >= BEEP_ON_B && sub_cnt < BEEP_OFF_B);

    r.hour          = hr_cnt;
    r.minute        = min_cnt;
    r.second        = sec_cnt;
    r.pm            = pm_flag;
    r.pill_count    = pill_cnt;
    r.beep_active   = warn;
    r.buzzer        = warn && in_win;
    r.alarm_pending = pend;
    r.no_pills      = empty;
    if (r.buzzer) buzz_words++;
    return r;
  endfunction

  // Every accepted event word gets its prediction queued on the same edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      awaited_words.push_back(clock_after_event(in_data));
      events_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  // One line per mismatch, capped so a dead DUT can't flood the log
  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic cmp_field(string name, int idx, logic [19:0] got, logic [19:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %0d, expected %0d", idx, name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    acpc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (awaited_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing awaited", words_checked));
      end else begin
        want = awaited_words.pop_front();
        cmp_field("hour", words_checked, 20'(out_data.hour), 20'(want.hour));
        cmp_field("minute", words_checked, 20'(out_data.minute), 20'(want.minute));
        cmp_field("second", words_checked, 20'(out_data.second), 20'(want.second));
        cmp_field("pm", words_checked, 20'(out_data.pm), 20'(want.pm));
        cmp_field("pill_count", words_checked, out_data.pill_count, want.pill_count);
        cmp_field("beep_active", words_checked, 20'(out_data.beep_active),
                  20'(want.beep_active));
        cmp_field("buzzer", words_checked, 20'(out_data.buzzer), 20'(want.buzzer));
        cmp_field("alarm_pending", words_checked, 20'(out_data.alarm_pending),
                  20'(want.alarm_pending));
        cmp_field("no_pills", words_checked, 20'(out_data.no_pills), 20'(want.no_pills));
      end
    end
  end

  // Result side back-pressure: random stall bursts of random length
  always @(posedge clk) begin
    if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 13);
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Event with random content in the fields the opcode ignores
  function automatic acpc_in_t make_event(logic [1:0] op);
    acpc_in_t w;
    w.opcode     = op;
    w.set_hour   = 4'($urandom_range(0, 15));
    w.set_minute = 6'($urandom_range(0, 63));
    w.set_pm     = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic acpc_in_t set_event(int h, int m, int p);
    acpc_in_t w;
    w.opcode     = OP_SET;
    w.set_hour   = 4'(h);
    w.set_minute = 6'(m);
    w.set_pm     = 1'(p);
    return w;
  endfunction

  // Half ticks, the rest presses and sets; a third of sets land on the alarm
  function automatic acpc_in_t rand_event();
    acpc_in_t w;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 50)      w = make_event(OP_TICK);
    else if (r < 63) w = make_event(OP_ADD);
    else if (r < 76) w = make_event(OP_TAKE);
    else if ($urandom_range(0, 2) == 0)
      w = set_event(int'(alm_hour), int'(alm_min), int'(alm_pm));
    else             w = make_event(OP_SET);
    return w;
  endfunction

  // Send one word. Valid stays up after acceptance so back-to-back words
  // don't toggle it; it only drops for a gap or in wait_idle.
  task automatic send_event(acpc_in_t w);
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_event(make_event(OP_TICK));
  endtask

  // Drop valid and let every awaited word come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_words.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Only called while idle; mirror follows the register width masking
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: thr_reg   = data;
      REG_ALM_HOUR:  alm_hour  = data[3:0];
      REG_ALM_MIN:   alm_min   = data[5:0];
      REG_ALM_PM:    alm_pm    = data[0];
      REG_ALM_ARMED: alm_armed = data[0];
      default: ;  // indexes past the last register do nothing
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset state, takes at zero, set-time clamping of hour and minute
  task automatic test_basic_ops();
    gap_pct   = 20;
    stall_pct = 20;
    send_event(make_event(OP_TAKE));  // empty: count held, no_pills
    send_event(make_event(OP_TAKE));
    send_event(make_event(OP_TICK));
    send_event(make_event(OP_ADD));
    send_event(make_event(OP_ADD));
    send_event(make_event(OP_TAKE));
    send_event(set_event(0, 0, 0));   // hour 0 loads 12
    send_event(set_event(13, 60, 1)); // 13 -> 12, 60 -> 59
    send_event(set_event(15, 63, 0));
    send_event(set_event(1, 0, 1));
    send_event(set_event(12, 59, 0));
    send_event(set_event(9, 37, 1));
    send_event(make_event(OP_TICK));
    send_event(make_event(OP_ADD));
  endtask

  // Match on set, re-pend on take during a matching second, register corners
  task automatic test_alarm_match();
    wait_idle();
    write_reg(REG_THRESHOLD, 20'd0);  // count never warns
    write_reg(REG_ALM_HOUR, 20'd7);
    write_reg(REG_ALM_MIN, 20'd30);
    write_reg(REG_ALM_PM, 20'd1);
    write_reg(REG_ALM_ARMED, 20'd1);
    send_event(set_event(7, 30, 1));  // match straight from a set
    send_event(make_event(OP_TAKE));  // ack, then pending again at once
    send_event(make_event(OP_TICK));
    send_event(make_event(OP_ADD));
    send_event(set_event(7, 31, 1));  // pending holds off the match
    send_event(make_event(OP_TAKE));  // clears it
    send_event(set_event(7, 30, 0));  // wrong half of day
    wait_idle();
    write_reg(REG_ALM_HOUR, 20'd0);   // alarm hour 0 never matches
    send_event(set_event(0, 30, 1));
    wait_idle();
    write_reg(REG_ALM_HOUR, 20'd12);
    write_reg(REG_ALM_MIN, 20'd60);   // minute 60 never matches
    send_event(set_event(12, 60, 1));
    wait_idle();
    write_reg(REG_ALM_MIN, 20'd59);
    write_reg(REG_ALM_ARMED, 20'd0);  // same time, disarmed
    send_event(set_event(12, 59, 1));
    wait_idle();
    // all-ones data: upper bits masked, dead indexes ignored
    write_reg(REG_THRESHOLD, 20'hFFFFF);
    write_reg(REG_ALM_HOUR, 20'hFFFFF);
    write_reg(REG_ALM_MIN, 20'hFFFFF);
    write_reg(REG_ALM_PM, 20'hFFFFF);
    write_reg(REG_ALM_ARMED, 20'hFFFFF);
    write_reg(3'd5, 20'hFFFFF);
    write_reg(3'd6, 20'hFFFFF);
    write_reg(3'd7, 20'hFFFFF);
    send_event(make_event(OP_ADD));
    send_event(make_event(OP_TAKE));
  endtask

  // Tick through subtick and second rollovers and both buzzer windows
  task automatic test_rollover();
    gap_pct   = 10;
    stall_pct = 10;
    wait_idle();
    write_reg(REG_THRESHOLD, PILL_MAX);
    write_reg(REG_ALM_HOUR, 20'd11);
    write_reg(REG_ALM_MIN, 20'd59);
    write_reg(REG_ALM_PM, 20'd0);
    write_reg(REG_ALM_ARMED, 20'd1);
    send_event(set_event(11, 59, 0)); // matches at once, pending set
    send_ticks(200);                  // two second rollovers, buzzer pulses
    send_event(make_event(OP_TAKE));  // past the matching second: clears
    send_event(make_event(OP_ADD));
    send_event(set_event(12, 59, 1));
    send_ticks(80);
  endtask

  // Random phases, each with its own settings and idle mix
  task automatic test_random();
    int ph;
    for (ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: write_reg(REG_THRESHOLD, 20'd0);
        1: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(1, 12)));
        2: write_reg(REG_THRESHOLD, PILL_MAX);
        3: write_reg(REG_THRESHOLD, 20'hFFFFF);
        default: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
      endcase
      write_reg(REG_ALM_HOUR,
                CFG_DATA_W'((ph == 4) ? $urandom_range(0, 15) : $urandom_range(1, 12)));
      write_reg(REG_ALM_MIN,
                CFG_DATA_W'((ph == 4) ? $urandom_range(0, 63) : $urandom_range(0, 59)));
      write_reg(REG_ALM_PM, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(REG_ALM_ARMED, CFG_DATA_W'(ph != 1));
      write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 15; stall_pct = 5;  end
        2: begin gap_pct = 40; stall_pct = 40; end
        3: begin gap_pct = 5;  stall_pct = 30; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      repeat (180) send_event(rand_event());
    end
  endtask

  // Last part, no idling on either side: random words back to back
  task automatic test_back_to_back();
    gap_pct   = 0;
    stall_pct = 0;
    wait_idle();
    write_reg(REG_THRESHOLD, 20'd3);
    while (stall_left != 0) @(posedge clk);
    repeat (90) send_event(rand_event());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_alarm_match();
    test_rollover();
    test_random();
    test_back_to_back();

    wait_idle();
    repeat (4) @(posedge clk);

    $display("Covered %0d events and %0d result words: presses, sets, second rollovers,",
             events_taken, words_checked);
    $display("alarm corners, %0d alarm hits, %0d empty takes, %0d buzzer words; %0d mismatches",
             alarm_hits, empty_takes, buzz_words, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** alarm_clock_pill_counter: PASSED **");
    end else begin
      $display("** alarm_clock_pill_counter: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/acpc_pkg.sv
hw/rtl/acpc_time.sv
hw/rtl/acpc_pill.sv
hw/rtl/alarm_clock_pill_counter.sv
tb/sv/tb_top.sv
